FILE: sv/sdt_pkg.sv
// Shared types, flag bits, mode codes and a saturating increment helper for the shadow tile demand table.
`timescale 1ns / 1ps
package sdt_pkg;

  localparam int CNT_W   = 13;
  localparam int COORD_W = 20;

  localparam logic [4:0] F_USED   = 5'd1;
  localparam logic [4:0] F_DIRECT = 5'd2;
  localparam logic [4:0] F_UPDATE = 5'd4;
  localparam logic [4:0] F_COARSE = 5'd8;
  localparam logic [4:0] F_MASKED = 5'd16;

  localparam logic [3:0] M_ORIGIN   = 4'd0;
  localparam logic [3:0] M_USED     = 4'd1;
  localparam logic [3:0] M_UPDATE   = 4'd2;
  localparam logic [3:0] M_RENDERED = 4'd3;
  localparam logic [3:0] M_RESET    = 4'd4;
  localparam logic [3:0] M_PROP     = 4'd5;
  localparam logic [3:0] M_MASK     = 4'd6;
  localparam logic [3:0] M_QUERY    = 4'd7;
  localparam logic [3:0] M_TALLY    = 4'd8;

  localparam logic [2:0] LEVEL_COUNT_RESET = 3'd6;

  typedef struct packed {
    logic [3:0]         mode;
    logic [2:0]         level;
    logic signed [15:0] tile_x;
    logic signed [15:0] tile_y;
  } in_item_t;

  typedef struct packed {
    logic [4:0]       tile_flags;
    logic             in_window;
    logic             requests_page;
    logic             needs_render;
    logic [CNT_W-1:0] newly_masked;
    logic [CNT_W-1:0] used_total;
    logic [CNT_W-1:0] update_total;
    logic [CNT_W-1:0] direct_total;
    logic [CNT_W-1:0] inherited_total;
    logic [CNT_W-1:0] masked_total;
    logic [CNT_W-1:0] render_total;
  } out_item_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
  endfunction

endpackage

FILE: sv/sdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sdt_ram #(
  parameter int W = 5,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [$clog2(D)-1:0] wr_addr,
  input  logic [W-1:0]         wr_data,
  input  logic                 rd_en,
  input  logic [$clog2(D)-1:0] rd_addr,
  output logic [W-1:0]         rd_data
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/sdt_addr.sv
// Shared tile locator: window offset, bounds check and row-major entry index.
`timescale 1ns / 1ps
module sdt_addr import sdt_pkg::*; #(
  parameter int RES = 32,
  parameter int LVW = 3,
  parameter int IW = 13
) (
  input  logic [LVW-1:0]            lvl,
  input  logic [LVW-1:0]            nact,
  input  logic signed [COORD_W-1:0] cx,
  input  logic signed [COORD_W-1:0] cy,
  input  logic signed [15:0]        ox,
  input  logic signed [15:0]        oy,
  output logic                      hit,
  output logic [IW-1:0]             idx
);

  localparam int LS = RES * RES;
  localparam logic signed [COORD_W-1:0] RES_S = COORD_W'(RES);

  logic signed [COORD_W-1:0] wx;
  logic signed [COORD_W-1:0] wy;

  assign wx = cx + $signed({{(COORD_W-16){ox[15]}}, ox});
  assign wy = cy + $signed({{(COORD_W-16){oy[15]}}, oy});

  assign hit = (lvl < nact) && (wx >= 0) && (wx < RES_S) && (wy >= 0) && (wy < RES_S);
  assign idx = IW'(lvl) * IW'(LS) + IW'(wy) * IW'(RES) + IW'(wx);

endmodule

FILE: sv/shadow_tile_demand_table.sv
// Top level: tile flag table with a sequencer around one locator and one RAM.
//
//   channel  | handshake          | payload
//   in       | in_valid/in_stall   | in_data (in_item_t)
//   out      | out_valid/out_stall | out_data (out_item_t)
//   cfg      | cfg_wr_en           | cfg_wr_data (level_count)
//
// Origin and undefined modes go straight to the result; marks and queries read the
// addressed entry, marks write it back. Reset demand rewrites every entry, tally
// reads each active-level entry, propagate visits fine and mask coarse tiles, paced
// by the single RAM read port. After reset a clearing pass first zeroes every entry.
// A result held by out_stall blocks completion of the next item, not its acceptance.
`timescale 1ns / 1ps
module shadow_tile_demand_table import sdt_pkg::*; #(
  parameter int RESOLUTION = 32,
  parameter int LEVELS = 6
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data
);

  localparam int LS  = RESOLUTION * RESOLUTION;
  localparam int TS  = LEVELS * LS;
  localparam int IW  = $clog2(TS);
  localparam int RW  = $clog2(RESOLUTION);
  localparam int LVW = ($clog2(LEVELS + 1) > 3) ? $clog2(LEVELS + 1) : 3;
  localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [RW-1:0] LAST = RW'(RESOLUTION - 1);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_PT_RD   = 4'd2;
  localparam logic [3:0] S_PT_WR   = 4'd3;
  localparam logic [3:0] S_LIN_RD  = 4'd4;
  localparam logic [3:0] S_LIN_WR  = 4'd5;
  localparam logic [3:0] S_PR_RD   = 4'd6;
  localparam logic [3:0] S_PR_CHK  = 4'd7;
  localparam logic [3:0] S_PR_PWR  = 4'd8;
  localparam logic [3:0] S_MK_RD   = 4'd9;
  localparam logic [3:0] S_MK_CHK  = 4'd10;
  localparam logic [3:0] S_MK_KRD  = 4'd11;
  localparam logic [3:0] S_MK_KCHK = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  logic [3:0]         state;
  in_item_t           item;
  out_item_t          res;
  logic [2:0]         level_count;
  logic signed [15:0] ox [LEVELS];
  logic signed [15:0] oy [LEVELS];
  logic [IW-1:0]      lin;
  logic [IW-1:0]      lin_end;
  logic [RW-1:0]      sx;
  logic [RW-1:0]      sy;
  logic [LVW-1:0]     lv;
  logic [1:0]         kid;
  logic [IW-1:0]      save_idx;
  logic [4:0]         save_w;
  logic               hit_r;
  logic signed [15:0] fo_x;
  logic signed [15:0] fo_y;

  logic [LVW-1:0]             nact;
  logic [LVW-1:0]             in_lvl;
  logic [LVW-1:0]             org_lvl;
  logic signed [15:0]         ox_sel;
  logic signed [15:0]         oy_sel;
  logic                       use_org;
  logic [LVW-1:0]             a_lvl;
  logic signed [COORD_W-1:0]  a_cx;
  logic signed [COORD_W-1:0]  a_cy;
  logic                       a_hit;
  logic [IW-1:0]              a_idx;
  logic signed [COORD_W-1:0]  gx;
  logic signed [COORD_W-1:0]  gy;
  logic signed [COORD_W-1:0]  fx;
  logic signed [COORD_W-1:0]  fy;
  logic [RW-1:0]              sx_next;
  logic [RW-1:0]              sy_next;
  logic                       grid_end;
  logic                       kid_ok;

  logic           rd_en;
  logic [IW-1:0]  rd_addr;
  logic [4:0]     rd_data;
  logic           wr_en;
  logic [IW-1:0]  wr_addr;
  logic [4:0]     wr_data;

  assign in_stall = (state != S_IDLE);
  assign nact     = (LVW'(level_count) < LVW'(LEVELS)) ? LVW'(level_count) : LVW'(LEVELS);
  assign in_lvl   = LVW'(in_data.level);

  assign ox_sel = (org_lvl < LVW'(LEVELS)) ? ox[org_lvl[LW-1:0]] : 16'sd0;
  assign oy_sel = (org_lvl < LVW'(LEVELS)) ? oy[org_lvl[LW-1:0]] : 16'sd0;

  assign gx = $signed({{(COORD_W-RW){1'b0}}, sx});
  assign gy = $signed({{(COORD_W-RW){1'b0}}, sy});
  assign fx = gx - $signed({{(COORD_W-16){fo_x[15]}}, fo_x});
  assign fy = gy - $signed({{(COORD_W-16){fo_y[15]}}, fo_y});

  assign grid_end = (sx == LAST) && (sy == LAST);
  assign sx_next  = (sx == LAST) ? '0 : sx + RW'(1);
  assign sy_next  = (sx == LAST) ? ((sy == LAST) ? '0 : sy + RW'(1)) : sy;
  assign kid_ok   = ((rd_data & F_USED) != '0) && ((rd_data & F_MASKED) == '0);

  always_comb begin
    a_lvl   = LVW'(item.level);
    a_cx    = $signed({{(COORD_W-16){item.tile_x[15]}}, item.tile_x});
    a_cy    = $signed({{(COORD_W-16){item.tile_y[15]}}, item.tile_y});
    org_lvl = LVW'(item.level);
    use_org = 1'b1;
    case (state)
      S_PR_RD, S_MK_RD: begin
        a_lvl   = lv;
        a_cx    = gx;
        a_cy    = gy;
        org_lvl = lv;
        use_org = 1'b0;
      end
      S_PR_CHK: begin
        a_lvl   = lv + LVW'(1);
        a_cx    = fx >>> 1;
        a_cy    = fy >>> 1;
        org_lvl = lv + LVW'(1);
      end
      S_MK_KRD: begin
        a_lvl   = lv - LVW'(1);
        a_cx    = (fx <<< 1) + $signed({{(COORD_W-1){1'b0}}, kid[0]});
        a_cy    = (fy <<< 1) + $signed({{(COORD_W-1){1'b0}}, kid[1]});
        org_lvl = lv - LVW'(1);
      end
      default: begin
      end
    endcase
  end

  sdt_addr #(
    .RES(RESOLUTION), .LVW(LVW), .IW(IW)
  ) u_addr (
    .lvl(a_lvl), .nact(nact), .cx(a_cx), .cy(a_cy),
    .ox(use_org ? ox_sel : 16'sd0), .oy(use_org ? oy_sel : 16'sd0),
    .hit(a_hit), .idx(a_idx)
  );

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = a_idx;
    wr_en   = 1'b0;
    wr_addr = save_idx;
    wr_data = '0;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = lin;
      end
      S_PT_RD: begin
        rd_en = a_hit;
      end
      S_PT_WR: begin
        wr_en = hit_r && (item.mode == M_USED || item.mode == M_UPDATE ||
                          item.mode == M_RENDERED);
        case (item.mode)
          M_USED:   wr_data = rd_data | F_USED | F_DIRECT;
          M_UPDATE: wr_data = rd_data | F_UPDATE;
          default:  wr_data = rd_data & ~F_UPDATE;
        endcase
      end
      S_LIN_RD: begin
        rd_en   = 1'b1;
        rd_addr = lin;
      end
      S_LIN_WR: begin
        wr_en   = (item.mode == M_RESET);
        wr_addr = lin;
        wr_data = rd_data & F_UPDATE;
      end
      S_PR_RD, S_MK_RD: begin
        rd_en = 1'b1;
      end
      S_PR_CHK: begin
        rd_en = a_hit && ((rd_data & F_USED) != '0);
      end
      S_PR_PWR: begin
        wr_en   = 1'b1;
        wr_data = rd_data | F_USED | F_COARSE;
      end
      S_MK_KRD: begin
        rd_en = a_hit;
      end
      S_MK_KCHK: begin
        wr_en   = kid_ok && (kid == 2'd3);
        wr_data = save_w | F_MASKED;
      end
      default: begin
      end
    endcase
  end

  sdt_ram #(.W(5), .D(TS)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      lin         <= '0;
      out_valid   <= 1'b0;
      level_count <= LEVEL_COUNT_RESET;
      for (int i = 0; i < LEVELS; i++) begin
        ox[i] <= '0;
        oy[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        level_count <= cfg_wr_data;
      end
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          lin <= lin + IW'(1);
          if (lin == IW'(TS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            res   <= '0;
            lin   <= '0;
            sx    <= '0;
            sy    <= '0;
            case (in_data.mode)
              M_ORIGIN: begin
                if (in_lvl < LVW'(LEVELS)) begin
                  ox[in_lvl[LW-1:0]] <= in_data.tile_x;
                  oy[in_lvl[LW-1:0]] <= in_data.tile_y;
                end
                state <= S_DONE;
              end
              M_USED, M_UPDATE, M_RENDERED, M_QUERY: begin
                state <= S_PT_RD;
              end
              M_RESET: begin
                lin_end <= IW'(TS - 1);
                state   <= S_LIN_RD;
              end
              M_PROP: begin
                lv    <= '0;
                state <= (nact >= LVW'(2)) ? S_PR_RD : S_DONE;
              end
              M_MASK: begin
                lv    <= nact - LVW'(1);
                state <= (nact >= LVW'(2)) ? S_MK_RD : S_DONE;
              end
              M_TALLY: begin
                lin_end <= IW'(LS) * IW'(nact) - IW'(1);
                state   <= (nact != '0) ? S_LIN_RD : S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_PT_RD: begin
          hit_r    <= a_hit;
          save_idx <= a_idx;
          state    <= S_PT_WR;
        end
        S_PT_WR: begin
          if (hit_r) begin
            res.in_window <= 1'b1;
            if (item.mode == M_QUERY) begin
              res.tile_flags    <= rd_data;
              res.requests_page <= kid_ok;
              res.needs_render  <= kid_ok && ((rd_data & F_UPDATE) != '0);
            end
          end
          state <= S_DONE;
        end
        S_LIN_RD: begin
          state <= S_LIN_WR;
        end
        S_LIN_WR: begin
          if (item.mode == M_TALLY) begin
            if ((rd_data & F_USED) != '0) res.used_total <= sat_inc(res.used_total);
            if ((rd_data & F_UPDATE) != '0) res.update_total <= sat_inc(res.update_total);
            if ((rd_data & F_DIRECT) != '0) res.direct_total <= sat_inc(res.direct_total);
            if ((rd_data & (F_COARSE | F_DIRECT)) == F_COARSE) begin
              res.inherited_total <= sat_inc(res.inherited_total);
            end
            if ((rd_data & F_MASKED) != '0) res.masked_total <= sat_inc(res.masked_total);
            if ((rd_data & (F_USED | F_UPDATE | F_MASKED)) == (F_USED | F_UPDATE)) begin
              res.render_total <= sat_inc(res.render_total);
            end
          end
          lin <= lin + IW'(1);
          state <= (lin == lin_end) ? S_DONE : S_LIN_RD;
        end
        S_PR_RD: begin
          fo_x  <= ox_sel;
          fo_y  <= oy_sel;
          state <= S_PR_CHK;
        end
        S_PR_CHK, S_PR_PWR: begin
          save_idx <= a_idx;
          if (state == S_PR_CHK && a_hit && ((rd_data & F_USED) != '0)) begin
            state <= S_PR_PWR;
          end else begin
            sx <= sx_next;
            sy <= sy_next;
            if (grid_end && lv == nact - LVW'(2)) begin
              state <= S_DONE;
            end else begin
              if (grid_end) lv <= lv + LVW'(1);
              state <= S_PR_RD;
            end
          end
        end
        S_MK_RD: begin
          fo_x     <= ox_sel;
          fo_y     <= oy_sel;
          save_idx <= a_idx;
          state    <= S_MK_CHK;
        end
        S_MK_CHK, S_MK_KRD, S_MK_KCHK: begin
          if (state == S_MK_CHK) begin
            save_w <= rd_data;
            kid    <= '0;
          end
          if (state == S_MK_KCHK && kid_ok && kid == 2'd3) begin
            res.newly_masked <= sat_inc(res.newly_masked);
          end
          if ((state == S_MK_CHK && (rd_data & (F_USED | F_COARSE | F_DIRECT | F_MASKED))
                 == (F_USED | F_COARSE)) || (state == S_MK_KRD && a_hit)) begin
            state <= (state == S_MK_CHK) ? S_MK_KRD : S_MK_KCHK;
          end else if (state == S_MK_KCHK && kid_ok && kid != 2'd3) begin
            kid   <= kid + 2'd1;
            state <= S_MK_KRD;
          end else begin
            sx <= sx_next;
            sy <= sy_next;
            if (grid_end && lv == LVW'(1)) begin
              state <= S_DONE;
            end else begin
              if (grid_end) lv <= lv - LVW'(1);
              state <= S_MK_RD;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/sdt_checker.sv
// Port-level checker for the shadow tile demand table and its bind.
`timescale 1ns / 1ps
module sdt_checker import sdt_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input out_item_t  out_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("held beat changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("beat accepted while busy");

  a_page: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.requests_page |->
      out_data.tile_flags[0] && !out_data.tile_flags[4] && out_data.in_window)
    else $error("page request without live tile");

  a_render: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.needs_render |-> out_data.requests_page && out_data.tile_flags[2])
    else $error("render without page request");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid && in_stall)
    else $error("reset left channels active");

endmodule

bind shadow_tile_demand_table sdt_checker u_sdt_checker (.*);
